// ===== rtl/core/nrps_pkg.sv =====
// Shared constants for the nearest ready point selector.
`timescale 1ns / 1ps
`default_nettype none

package nrps_pkg;

  // Fixed field widths of the item and result ports
  localparam int unsigned LIMIT_W = 17;
  localparam int unsigned INDEX_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd50000;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/nrps_sq_dist.sv =====
// Registered squared-difference stage of the distance datapath.
`timescale 1ns / 1ps
`default_nettype none

module nrps_sq_dist #(
  parameter int unsigned COORD_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [COORD_BITS-1:0]   a_x,
  input  wire logic [COORD_BITS-1:0]   a_y,
  input  wire logic [COORD_BITS-1:0]   b_x,
  input  wire logic [COORD_BITS-1:0]   b_y,
  output logic      [2*COORD_BITS:0]   sq_sum
);

  logic [COORD_BITS-1:0]   dx;
  logic [COORD_BITS-1:0]   dy;
  logic [2*COORD_BITS-1:0] sq_x_r;
  logic [2*COORD_BITS-1:0] sq_y_r;

  assign dx = (a_x >= b_x) ? (a_x - b_x) : (b_x - a_x);
  assign dy = (a_y >= b_y) ? (a_y - b_y) : (b_y - a_y);

  // hold the squares in registers, add them in the next stage
  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r <= (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
      sq_y_r <= (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
    end
  end

  assign sq_sum = {1'b0, sq_x_r} + {1'b0, sq_y_r};

endmodule

`default_nettype wire

// ===== rtl/core/nearest_ready_point_selector.sv =====
// Top level of the nearest ready point selector: point table, scan FSM, result register.
// Flow: a write goes through DONE into the result register; a query through SCAN, DRAIN
//   and DONE. DONE waits while the output slot is not free.
// Handshake: one item at a time; the next transfer is taken only once the result has
//   loaded and the FSM is back in IDLE.
// Reset: marks clear, distance_limit returns to 50000, output empties; point memory kept.
`timescale 1ns / 1ps
`default_nettype none

module nearest_ready_point_selector #(
  parameter int unsigned NUM_POINTS = 20,
  parameter int unsigned COORD_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  // configuration: distance_limit
  input  wire logic                          cfg_wr_en,
  input  wire logic [nrps_pkg::LIMIT_W-1:0]  cfg_wr_data,

  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_operation,
  input  wire logic [nrps_pkg::INDEX_W-1:0]  in_slot_index,
  input  wire logic [COORD_BITS-1:0]         in_point_x,
  input  wire logic [COORD_BITS-1:0]         in_point_y,
  input  wire logic                          in_point_ready,
  input  wire logic [COORD_BITS-1:0]         in_pos_x,
  input  wire logic [COORD_BITS-1:0]         in_pos_y,

  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [nrps_pkg::INDEX_W-1:0]  out_nearest_index,
  output logic      [nrps_pkg::LIMIT_W-1:0]  out_nearest_distance,
  output logic                               out_none_found
);

  localparam int unsigned IDX_W  = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int unsigned DIST_W = 2 * COORD_BITS + 1;
  localparam int unsigned BEST_W = (DIST_W > nrps_pkg::LIMIT_W) ? DIST_W : nrps_pkg::LIMIT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);

  // FSM codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]              state_r;
  logic [1:0]              state_nxt;

  logic [nrps_pkg::LIMIT_W-1:0] limit_r;

  // ready marks live in flops so reset can clear them at once
  logic [NUM_POINTS-1:0]   ready_r;

  // point memory: {x, y} per entry, registered read port
  logic [2*COORD_BITS-1:0] pt_mem [NUM_POINTS];
  logic [2*COORD_BITS-1:0] rd_data_r;

  logic                    in_xfer;
  logic                    wr_ok;
  logic [IDX_W-1:0]        wr_idx;
  logic                    mem_we;

  logic [COORD_BITS-1:0]   pos_x_r;
  logic [COORD_BITS-1:0]   pos_y_r;

  // scan pipeline
  logic [IDX_W-1:0]        cnt_r;
  logic                    s1_v_r;
  logic [IDX_W-1:0]        s1_idx_r;
  logic                    s2_v_r;
  logic [IDX_W-1:0]        s2_idx_r;
  logic [DIST_W-1:0]       sq_sum;
  logic [BEST_W-1:0]       dist_ext;

  // running best candidate
  logic [BEST_W-1:0]       best_d_r;
  logic [IDX_W-1:0]        best_idx_r;
  logic                    found_r;

  logic                    out_free;

  // ---------------------------------------------------------------------------
  // Handshake: take one item at a time, only from the idle state. A finished
  // result already in the output register does not block the next transfer.
  // ---------------------------------------------------------------------------
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // drop writes beyond the table
  assign wr_ok  = (32'(in_slot_index) < NUM_POINTS);
  assign wr_idx = IDX_W'(in_slot_index);
  assign mem_we = in_xfer && (in_operation == nrps_pkg::OP_WRITE) && wr_ok;

  // ---------------------------------------------------------------------------
  // FSM: IDLE -> (write) DONE, IDLE -> (query) SCAN -> DRAIN -> DONE -> IDLE
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_operation == nrps_pkg::OP_WRITE) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait until the last entry has passed the compare stage
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= nrps_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Point memory. Writes happen only at a transfer in IDLE and read data is used
  // only during the scan, so the FSM itself keeps the two from overlapping.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pt_mem[wr_idx] <= {in_point_x, in_point_y};
    end
    rd_data_r <= pt_mem[cnt_r];
  end

  // Ready marks: set or clear on a write, clear the chosen one when the scan ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= '0;
    end else if (mem_we) begin
      ready_r[wr_idx] <= in_point_ready;
    end else if (state_r == S_DRAIN && state_nxt == S_DONE && found_r) begin
      ready_r[best_idx_r] <= 1'b0;
    end
  end

  // latch the query position for the whole scan
  always_ff @(posedge clk) begin
    if (in_xfer && in_operation == nrps_pkg::OP_QUERY) begin
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
    end
  end

  // ---------------------------------------------------------------------------
  // Scan pipeline: issue address, read data, squares, sum and compare.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        cnt_r <= '0;
      end else if (state_r == S_SCAN && cnt_r != LAST_IDX) begin
        cnt_r <= cnt_r + 1'b1;
      end
      s1_v_r <= (state_r == S_SCAN);
      // only ready entries go on to the compare
      s2_v_r <= s1_v_r && ready_r[s1_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= cnt_r;
    s2_idx_r <= s1_idx_r;
  end

  nrps_sq_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_sq_dist (
    .clk    (clk),
    .en     (s1_v_r),
    .a_x    (rd_data_r[2*COORD_BITS-1:COORD_BITS]),
    .a_y    (rd_data_r[COORD_BITS-1:0]),
    .b_x    (pos_x_r),
    .b_y    (pos_y_r),
    .sq_sum (sq_sum)
  );

  assign dist_ext = BEST_W'(sq_sum);

  // Best starts at the limit, so only distances strictly below it win. A strict
  // compare keeps the lowest index on a tie, since the scan runs upward.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (in_xfer) begin
      found_r <= 1'b0;
    end else if (s2_v_r && dist_ext < best_d_r) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      best_d_r   <= BEST_W'(limit_r);
      best_idx_r <= '0;
    end else if (s2_v_r && dist_ext < best_d_r) begin
      best_d_r   <= dist_ext;
      best_idx_r <= s2_idx_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: load from DONE when the slot is free, empty it on transfer.
  // A write item leaves found_r clear and so reports none_found.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_nearest_index    <= found_r ? nrps_pkg::INDEX_W'(best_idx_r) : '0;
      out_nearest_distance <= found_r ? nrps_pkg::LIMIT_W'(best_d_r) : '0;
      out_none_found       <= !found_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!s1_v_r && !s2_v_r))
    else $error("scan pipeline busy while idle");

  a_s2_follows_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> $past(s1_v_r))
    else $error("compare stage valid without a read before it");

  a_mark_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_DRAIN && state_r == S_DONE && found_r) |-> !ready_r[best_idx_r])
    else $error("chosen point still marked ready");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_DRAIN) |-> in_stall)
    else $error("input not stalled during a scan");

endmodule

`default_nettype wire

// ===== bench/tb_nearest_ready_point_selector.sv =====
// Self-checking testbench for the nearest ready point selector.
`timescale 1ns / 1ps

module tb_nearest_ready_point_selector;

  localparam int unsigned LIMIT_W = nrps_pkg::LIMIT_W;
  localparam int unsigned INDEX_W = nrps_pkg::INDEX_W;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = nrps_pkg::LIMIT_RESET;
  localparam logic OP_WRITE = nrps_pkg::OP_WRITE;
  localparam logic OP_QUERY = nrps_pkg::OP_QUERY;

  localparam int unsigned NUM_POINTS  = 20;
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned HOLD_CYCLES = 400;   // long receiver hold-off for the pressure test
  localparam int unsigned SETTLE      = NUM_POINTS + 10;
  localparam int unsigned STUCK_LIMIT = 2000;  // cycles without any transfer before giving up
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  typedef struct packed {
    logic               op;
    logic [INDEX_W-1:0] slot;
    logic [COORD_W-1:0] pt_x;
    logic [COORD_W-1:0] pt_y;
    logic               pt_ready;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
  } selector_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] nearest_idx;
    logic [LIMIT_W-1:0] nearest_dist;
    logic               none_found;
  } selector_answer_t;

  logic clk = 1'b0;
  logic rst_n;

  logic               cfg_wr_en;
  logic [LIMIT_W-1:0] cfg_wr_data;

  logic               in_valid;
  logic               in_stall;
  logic               in_operation;
  logic [INDEX_W-1:0] in_slot_index;
  logic [COORD_W-1:0] in_point_x;
  logic [COORD_W-1:0] in_point_y;
  logic               in_point_ready;
  logic [COORD_W-1:0] in_pos_x;
  logic [COORD_W-1:0] in_pos_y;

  logic               out_valid;
  logic               out_stall;
  logic [INDEX_W-1:0] out_nearest_index;
  logic [LIMIT_W-1:0] out_nearest_distance;
  logic               out_none_found;

  // Shadow of the block's state, updated as items transfer in
  logic [COORD_W-1:0]    shadow_x [NUM_POINTS];
  logic [COORD_W-1:0]    shadow_y [NUM_POINTS];
  logic [NUM_POINTS-1:0] shadow_ready = '0;
  logic [LIMIT_W-1:0]    shadow_limit = LIMIT_RESET;

  selector_answer_t pending_answers[$];

  // Idle control: sender gaps, receiver stalls, and the long hold-off
  bit send_idle    = 1'b1;
  bit sink_idle    = 1'b1;
  bit hold_request = 1'b0;
  bit hold_results = 1'b0;

  int unsigned items_sent      = 0;
  int unsigned queries_sent    = 0;
  int unsigned answers_checked = 0;
  int unsigned points_picked   = 0;
  int unsigned limit_writes    = 0;
  int unsigned errors          = 0;
  int unsigned stuck_cycles    = 0;

  nearest_ready_point_selector #(
    .NUM_POINTS (NUM_POINTS),
    .COORD_BITS (COORD_W)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_slot_index        (in_slot_index),
    .in_point_x           (in_point_x),
    .in_point_y           (in_point_y),
    .in_point_ready       (in_point_ready),
    .in_pos_x             (in_pos_x),
    .in_pos_y             (in_pos_y),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_nearest_index    (out_nearest_index),
    .out_nearest_distance (out_nearest_distance),
    .out_none_found       (out_none_found)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one item to the shadow state and return the answer the block must give.
  // Writes always answer "none found"; a query picks the closest ready point
  // strictly under the limit, lowest index on a tie, and clears its mark.
  function automatic selector_answer_t select_nearest(input selector_item_t it);
    selector_answer_t ans;
    int unsigned      best;
    int unsigned      sq_dist;
    int               dx;
    int               dy;
    int               chosen;
    ans    = '{nearest_idx: '0, nearest_dist: '0, none_found: 1'b1};
    chosen = -1;
    if (it.op == OP_WRITE) begin
      // out-of-range slots are dropped by the block
      if (it.slot < NUM_POINTS) begin
        shadow_x[it.slot]     = it.pt_x;
        shadow_y[it.slot]     = it.pt_y;
        shadow_ready[it.slot] = it.pt_ready;
      end
    end else begin
      best = 32'(shadow_limit);
      for (int i = 0; i < NUM_POINTS; i++) begin
        if (shadow_ready[i]) begin
          dx      = int'(shadow_x[i]) - int'(it.pos_x);
          dy      = int'(shadow_y[i]) - int'(it.pos_y);
          sq_dist = dx * dx + dy * dy;
          // strict compare keeps the lowest index on a tie
          if (sq_dist < best) begin
            best   = sq_dist;
            chosen = i;
          end
        end
      end
      if (chosen >= 0) begin
        shadow_ready[chosen] = 1'b0;
        ans.nearest_idx      = chosen[INDEX_W-1:0];
        ans.nearest_dist     = best[LIMIT_W-1:0];
        ans.none_found       = 1'b0;
      end
    end
    return ans;
  endfunction

  // Build items; the fields that the operation ignores get random junk.
  function automatic selector_item_t make_write(input int unsigned slot, input int unsigned x,
                                                input int unsigned y, input bit rdy);
    selector_item_t it;
    it.op       = OP_WRITE;
    it.slot     = slot[INDEX_W-1:0];
    it.pt_x     = x[COORD_W-1:0];
    it.pt_y     = y[COORD_W-1:0];
    it.pt_ready = rdy;
    it.pos_x    = COORD_W'($urandom_range(0, 255));
    it.pos_y    = COORD_W'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic selector_item_t make_query(input int unsigned x, input int unsigned y);
    selector_item_t it;
    it.op       = OP_QUERY;
    it.slot     = INDEX_W'($urandom_range(0, 31));
    it.pt_x     = COORD_W'($urandom_range(0, 255));
    it.pt_y     = COORD_W'($urandom_range(0, 255));
    it.pt_ready = 1'($urandom_range(0, 1));
    it.pos_x    = x[COORD_W-1:0];
    it.pos_y    = y[COORD_W-1:0];
    return it;
  endfunction

  // Coordinates: edges, a tight cluster that breeds ties, and the full range.
  function automatic int unsigned random_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return 0;
      1:       return 255;
      2, 3:    return $urandom_range(120, 136);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic selector_item_t random_item();
    int unsigned slot;
    if ($urandom_range(0, 99) < 55) begin
      // mostly valid slots, now and then an out-of-range one between the table size and 31
      if ($urandom_range(0, 19) == 0) slot = $urandom_range(NUM_POINTS, 31);
      else slot = $urandom_range(0, NUM_POINTS - 1);
      return make_write(slot, random_coord(), random_coord(), $urandom_range(0, 3) != 0);
    end
    return make_query(random_coord(), random_coord());
  endfunction

  // Offer one item and hold it until the block takes it. Called at a falling edge;
  // returns at the falling edge after the transfer.
  task automatic send_item(input selector_item_t it);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation   <= it.op;
    in_slot_index  <= it.slot;
    in_point_x     <= it.pt_x;
    in_point_y     <= it.pt_y;
    in_point_ready <= it.pt_ready;
    in_pos_x       <= it.pos_x;
    in_pos_y       <= it.pos_y;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid, wait for every outstanding answer, then let the scan settle.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_answers.size() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    shadow_limit  = value;
    limit_writes++;
    @(negedge clk);
  endtask

  task automatic test_empty_and_out_of_range();
    send_item(make_query(10, 10));                 // nothing ready yet
    send_item(make_write(NUM_POINTS, 5, 5, 1'b1)); // first slot past the table
    send_item(make_write(31, 255, 0, 1'b1));       // largest slot code
    send_item(make_query(5, 5));                   // dropped writes must stay invisible
    wait_until_idle();
  endtask

  task automatic test_coordinate_extremes();
    send_item(make_write(0, 0, 0, 1'b1));
    send_item(make_write(NUM_POINTS - 1, 255, 255, 1'b1));
    send_item(make_query(255, 255));
    send_item(make_query(0, 0));
    send_item(make_query(128, 128));               // both marks cleared by now
    wait_until_idle();
  endtask

  task automatic test_tie_and_not_ready();
    send_item(make_write(3, 100, 100, 1'b1));
    send_item(make_write(7, 110, 100, 1'b1));
    send_item(make_write(5, 105, 100, 1'b0));      // closest, but not waiting
    send_item(make_query(105, 100));               // tie: lower index first
    send_item(make_query(105, 100));
    send_item(make_query(105, 100));
    wait_until_idle();
  endtask

  task automatic test_limit_edges();
    write_limit('0);                               // nothing can qualify
    send_item(make_write(2, 50, 50, 1'b1));
    send_item(make_query(50, 50));
    wait_until_idle();
    write_limit(LIMIT_W'(100));                    // distance equal to limit is rejected
    send_item(make_query(60, 50));
    wait_until_idle();
    write_limit(LIMIT_W'(101));
    send_item(make_query(60, 50));
    wait_until_idle();
    write_limit(LIMIT_MAX);                        // corner to corner now qualifies
    send_item(make_write(4, 0, 0, 1'b1));
    send_item(make_query(255, 255));
    wait_until_idle();
    write_limit(LIMIT_RESET);
  endtask

  // Hold the receiver for a long stretch while items keep coming, so the
  // block fills and stalls its input.
  task automatic test_result_backpressure();
    send_idle    = 1'b0;
    sink_idle    = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_item(random_item());
    wait_until_idle();
  endtask

  task automatic test_random_traffic(input int unsigned count, input logic [LIMIT_W-1:0] limit,
                                     input bit sender_gaps, input bit receiver_gaps);
    write_limit(limit);
    send_idle = sender_gaps;
    sink_idle = receiver_gaps;
    repeat (count) send_item(random_item());
    wait_until_idle();
  endtask

  initial begin : stimulus_flow
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    in_operation   <= OP_WRITE;
    in_slot_index  <= '0;
    in_point_x     <= '0;
    in_point_y     <= '0;
    in_point_ready <= 1'b0;
    in_pos_x       <= '0;
    in_pos_y       <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_and_out_of_range();
    test_coordinate_extremes();
    test_tie_and_not_ready();
    test_limit_edges();
    test_result_backpressure();
    test_random_traffic(200, LIMIT_RESET, 1'b1, 1'b1);
    test_random_traffic(200, LIMIT_W'($urandom_range(0, 131071)), 1'b1, 1'b0);
    test_random_traffic(200, LIMIT_MAX, 1'b0, 1'b1);
    test_random_traffic(200, LIMIT_W'(3000), 1'b0, 1'b0);
    test_random_traffic(50, '0, 1'b1, 1'b1);
    test_random_traffic(200, LIMIT_W'($urandom_range(0, 131071)), 1'b1, 1'b1);
    test_random_traffic(150, LIMIT_W'($urandom_range(1, 400)), 1'b1, 1'b1);

    $display("covered %0d items (%0d queries) over %0d limit settings;", items_sent,
             queries_sent, limit_writes);
    $display("checked %0d answers, %0d of them picked a point", answers_checked, points_picked);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: stall each answer for a random count of cycles, or hold
  // everything while the long hold-off runs.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_stall <= 1'b1;
      end else if (out_valid && stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        // this answer transfers at the next rising edge; draw the next stall
        if (out_valid) stall_left = sink_idle ? $urandom_range(0, 18) : 0;
      end
    end
  end

  // Count the hold-off on rising edges; the receiver reads the flag at falling edges.
  initial begin : result_hold_off
    forever begin
      wait (hold_request);
      @(posedge clk);
      hold_results = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_results = 1'b0;
      hold_request = 1'b0;
    end
  end

  task automatic report_field(input string name, input int unsigned exp_val,
                              input logic [LIMIT_W-1:0] act_val);
    $display("%0t: mismatch on %s, expected %0d, got %0d", $time, name, exp_val, act_val);
    errors++;
  endtask

  // Sample both channels at the rising edge. Check the answer first, then
  // predict for the item taken in on the same edge.
  always @(posedge clk) begin : transfer_monitor
    selector_answer_t exp_ans;
    selector_item_t   taken;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: answer with none outstanding, got index %0d distance %0d flag %0b",
                 $time, out_nearest_index, out_nearest_distance, out_none_found);
        errors++;
      end else begin
        exp_ans = pending_answers.pop_front();
        answers_checked++;
        if (!exp_ans.none_found) points_picked++;
        if (out_nearest_index !== exp_ans.nearest_idx)
          report_field("nearest_index", 32'(exp_ans.nearest_idx),
                       LIMIT_W'(out_nearest_index));
        if (out_nearest_distance !== exp_ans.nearest_dist)
          report_field("nearest_distance", 32'(exp_ans.nearest_dist), out_nearest_distance);
        if (out_none_found !== exp_ans.none_found)
          report_field("none_found", 32'(exp_ans.none_found), LIMIT_W'(out_none_found));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      taken = '{op: in_operation, slot: in_slot_index, pt_x: in_point_x, pt_y: in_point_y,
                pt_ready: in_point_ready, pos_x: in_pos_x, pos_y: in_pos_y};
      pending_answers.push_back(select_nearest(taken));
      items_sent++;
      if (taken.op == OP_QUERY) queries_sent++;
    end
  end

  // Give up when neither channel has moved for too long.
  always @(posedge clk) begin : stuck_watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d answers outstanding", $time,
               STUCK_LIMIT, pending_answers.size());
      $display("simulation failed");
      $finish;
    end
  end

endmodule
